### design/assert_macros.svh
// Assertion macros used by the dictionary encoder checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, skipped while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion, also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### design/dict_enc_pkg.sv
// Shared types and constants for the dictionary encoder.
// No dependencies.
package dict_enc_pkg;

  localparam int DICT_DEPTH_DEF  = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int DICT_CAP_W = 11;
  localparam int PAGE_CAP_W = 16;

  localparam logic [DICT_CAP_W-1:0] DICT_CAP_RST = 11'd1024;
  localparam logic [PAGE_CAP_W-1:0] PAGE_CAP_RST = 16'hFFFF;

  // configuration register indexes
  localparam logic REG_DICT_CAP = 1'b0;
  localparam logic REG_PAGE_CAP = 1'b1;

  // input item modes
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // page encodings
  localparam logic ENC_DICT  = 1'b0;
  localparam logic ENC_PLAIN = 1'b1;

  // search token handed from cell to cell
  typedef struct packed {
    logic vld;
    logic hit;
  } cell_ctl_t;

endpackage

### design/dict_enc_cell.sv
// One dictionary cell: holds one entry and compares it with the broadcast query
// as the search token passes. Depends on dict_enc_pkg.
module dict_enc_cell #(
  parameter int VALUE_WIDTH = dict_enc_pkg::VALUE_WIDTH_DEF,
  parameter int CODE_W      = 10,
  parameter int CNT_W       = 11,
  parameter int IDX         = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [VALUE_WIDTH-1:0]     query,
  input  logic [CNT_W-1:0]           dict_count,
  input  logic                       ins_en,
  input  logic [CODE_W-1:0]          ins_addr,
  input  logic [VALUE_WIDTH-1:0]     ins_data,
  input  dict_enc_pkg::cell_ctl_t    ctl_in,
  input  logic [CODE_W-1:0]          code_in,
  output dict_enc_pkg::cell_ctl_t    ctl_out,
  output logic [CODE_W-1:0]          code_out
);

  logic [VALUE_WIDTH-1:0] entry;
  logic                   in_use;
  logic                   match;

  // only entries below the fill count hold real values
  assign in_use = CNT_W'(IDX) < dict_count;
  assign match  = in_use && (entry == query);

  always_ff @(posedge clk) begin
    if (ins_en && (ins_addr == CODE_W'(IDX))) begin
      entry <= ins_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out.vld <= ctl_in.vld;
      ctl_out.hit <= ctl_in.hit | (ctl_in.vld & match);
    end
  end

  // entries are unique, so the first hit is the only hit
  always_ff @(posedge clk) begin
    code_out <= ctl_in.hit ? code_in : CODE_W'(IDX);
  end

endmodule

### design/dictionary_encoder_with_fallback.sv
// Top level of the dictionary encoder with plain-mode fallback.
// Depends on dict_enc_pkg and dict_enc_cell.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item: mode 0 adds a value,
//   mode 1 finishes the page. Output channel (out_valid / out_stall) returns
//   one result per item, in order. Configuration (wr_en, wr_index, wr_data)
//   sets dictionary and page capacity; write only while the block is idle.
//   Timing: a dictionary-mode add registers the query, then launches a search
//   token and passes it down the chain of DICT_DEPTH cells, one cell per
//   cycle; the result is registered in the evaluate state once the result
//   register is free. A finish or a plain-mode add skips the search.
//   One item is in work at a time; in_stall is high while it is.
//   The result register holds while out_stall is high; the block may accept
//   the next item meanwhile, but its result waits until the register frees.
//   Reset: counts, mode and first value clear, capacities return to 1024 and
//   65535. Dictionary entries are not cleared; the fill count masks them.
module dictionary_encoder_with_fallback #(
  parameter  int DICT_DEPTH  = dict_enc_pkg::DICT_DEPTH_DEF,
  parameter  int VALUE_WIDTH = dict_enc_pkg::VALUE_WIDTH_DEF,
  localparam int CODE_W      = $clog2(DICT_DEPTH),
  localparam int CNT_W       = $clog2(DICT_DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic                              wr_index,
  input  logic [dict_enc_pkg::PAGE_CAP_W-1:0] wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              mode,
  input  logic [VALUE_WIDTH-1:0]            value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              accepted,
  output logic                              encoding,
  output logic [CODE_W-1:0]                 code,
  output logic [VALUE_WIDTH-1:0]            value_out,
  output logic                              page_full,
  output logic [VALUE_WIDTH-1:0]            first_value,
  output logic [dict_enc_pkg::PAGE_CAP_W-1:0] page_items
);

  localparam int CAP_W = dict_enc_pkg::DICT_CAP_W;
  localparam int PG_W  = dict_enc_pkg::PAGE_CAP_W;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_EVAL   = 2'd2;

  logic [1:0]             state;
  logic [CAP_W-1:0]       dict_cap;
  logic [PG_W-1:0]        page_cap;
  logic [CNT_W-1:0]       dict_count;
  logic [PG_W-1:0]        page_count;
  logic                   plain_mode;
  logic [VALUE_WIDTH-1:0] first_seen;
  logic                   q_mode;
  logic [VALUE_WIDTH-1:0] q_value;
  logic                   s_hit;
  logic [CODE_W-1:0]      s_code;
  logic                   go;

  logic in_fire;
  logic start;
  logic out_free;
  logic eval_fire;

  dict_enc_pkg::cell_ctl_t ctl_chain  [0:DICT_DEPTH];
  logic [CODE_W-1:0]       code_chain [0:DICT_DEPTH];

  // evaluation of the held item
  logic [CMP_W-1:0]       dict_lim;
  logic                   dict_full_cur;
  logic                   dict_full_nx;
  logic                   ins;
  logic                   room;
  logic                   take;
  logic [CNT_W-1:0]       dict_count_next;
  logic [PG_W-1:0]        page_count_next;
  logic                   plain_mode_next;
  logic [VALUE_WIDTH-1:0] first_seen_next;
  logic                   r_accepted;
  logic [CODE_W-1:0]      r_code;
  logic [VALUE_WIDTH-1:0] r_value_out;
  logic                   r_full;
  logic [VALUE_WIDTH-1:0] r_first;
  logic [PG_W-1:0]        r_items;

  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign start     = in_fire && (mode == dict_enc_pkg::MODE_ADD) && !plain_mode;
  assign out_free  = !out_valid || !out_stall;
  assign eval_fire = (state == ST_EVAL) && out_free;

  // token enters the chain once q_value holds the query
  always_ff @(posedge clk) begin
    if (rst) begin
      go <= 1'b0;
    end else begin
      go <= start;
    end
  end

  // search chain
  assign ctl_chain[0]  = '{vld: go, hit: 1'b0};
  assign code_chain[0] = '0;

  for (genvar g = 0; g < DICT_DEPTH; g++) begin : g_cell
    dict_enc_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CODE_W      (CODE_W),
      .CNT_W       (CNT_W),
      .IDX         (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .query      (q_value),
      .dict_count (dict_count),
      .ins_en     (eval_fire && ins),
      .ins_addr   (dict_count[CODE_W-1:0]),
      .ins_data   (q_value),
      .ctl_in     (ctl_chain[g]),
      .code_in    (code_chain[g]),
      .ctl_out    (ctl_chain[g+1]),
      .code_out   (code_chain[g+1])
    );
  end

  // effective dictionary limit is min(capacity, depth)
  assign dict_lim = (CMP_W'(dict_cap) > CMP_W'(DICT_DEPTH)) ? CMP_W'(DICT_DEPTH)
                                                            : CMP_W'(dict_cap);
  assign dict_full_cur = CMP_W'(dict_count) >= dict_lim;

  always_comb begin
    ins             = 1'b0;
    take            = 1'b0;
    room            = page_count < page_cap;
    r_code          = '0;
    r_value_out     = '0;
    r_first         = '0;
    r_items         = '0;
    plain_mode_next = plain_mode;
    first_seen_next = first_seen;
    if (q_mode == dict_enc_pkg::MODE_FINISH) begin
      r_full  = (page_count >= page_cap) || (!plain_mode && dict_full_cur);
      r_items = page_count;
      r_first = (page_count != '0) ? first_seen : '0;
      if (!plain_mode && dict_full_cur) begin
        plain_mode_next = 1'b1;
      end
      first_seen_next = '0;
    end else begin
      if (page_count == '0) begin
        first_seen_next = q_value;
      end
      if (plain_mode) begin
        take        = room;
        r_value_out = room ? q_value : '0;
      end else begin
        ins    = !s_hit && !dict_full_cur;
        take   = (s_hit || ins) && room;
        r_code = s_hit ? s_code : (ins ? dict_count[CODE_W-1:0] : '0);
      end
      r_full = 1'b0;
    end
    dict_count_next = dict_count + CNT_W'(ins);
    page_count_next = (q_mode == dict_enc_pkg::MODE_FINISH) ? '0
                                                            : page_count + PG_W'(take);
    dict_full_nx    = CMP_W'(dict_count_next) >= dict_lim;
    if (q_mode == dict_enc_pkg::MODE_ADD) begin
      r_full = (page_count_next >= page_cap) || (!plain_mode && dict_full_nx);
    end
    r_accepted = take;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dict_cap <= dict_enc_pkg::DICT_CAP_RST;
      page_cap <= dict_enc_pkg::PAGE_CAP_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        dict_enc_pkg::REG_DICT_CAP: dict_cap <= wr_data[CAP_W-1:0];
        dict_enc_pkg::REG_PAGE_CAP: page_cap <= wr_data;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= start ? ST_SEARCH : ST_EVAL;
          end
        end
        ST_SEARCH: begin
          if (ctl_chain[DICT_DEPTH].vld) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_mode  <= mode;
      q_value <= value;
    end
    if (ctl_chain[DICT_DEPTH].vld) begin
      s_hit  <= ctl_chain[DICT_DEPTH].hit;
      s_code <= code_chain[DICT_DEPTH];
    end
  end

  // encoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      dict_count <= '0;
      page_count <= '0;
      plain_mode <= 1'b0;
      first_seen <= '0;
    end else if (eval_fire) begin
      dict_count <= dict_count_next;
      page_count <= page_count_next;
      plain_mode <= plain_mode_next;
      first_seen <= first_seen_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eval_fire) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_fire) begin
      accepted    <= r_accepted;
      encoding    <= plain_mode ? dict_enc_pkg::ENC_PLAIN : dict_enc_pkg::ENC_DICT;
      code        <= r_code;
      value_out   <= r_value_out;
      page_full   <= r_full;
      first_value <= r_first;
      page_items  <= r_items;
    end
  end

endmodule

### design/dict_enc_checker.sv
// Port-level checks for the dictionary encoder, bound to the top level.
// Depends on dict_enc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dict_enc_checker #(
  parameter int VALUE_WIDTH = dict_enc_pkg::VALUE_WIDTH_DEF,
  parameter int CODE_W      = 10
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                accepted,
  input logic                                encoding,
  input logic [CODE_W-1:0]                   code,
  input logic [VALUE_WIDTH-1:0]              value_out,
  input logic [dict_enc_pkg::PAGE_CAP_W-1:0] page_items
);

  // a held result stays offered
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid)

  // one transaction in work at a time
  `ASSERT_CLK(a_one_at_a_time, clk, rst, in_valid && !in_stall |=> in_stall)

  // plain pages never carry codes
  `ASSERT_CLK(a_plain_no_code, clk, rst,
    out_valid && (encoding == dict_enc_pkg::ENC_PLAIN) |-> code == '0)

  // a raw value is passed only when taken
  `ASSERT_CLK(a_vout_on_accept, clk, rst, out_valid && !accepted |-> value_out == '0)

  // a finish report with items takes nothing in
  `ASSERT_CLK(a_finish_clean, clk, rst,
    out_valid && (page_items != '0) |-> !accepted && (code == '0) && (value_out == '0))

endmodule

bind dictionary_encoder_with_fallback dict_enc_checker #(
  .VALUE_WIDTH (VALUE_WIDTH),
  .CODE_W      (CODE_W)
) u_dict_enc_checker (.*);
